// ----- hw/rtl/swmc_pkg.sv -----
// shared constants and types for the sliding window median cost block
package swmc_pkg;

    localparam int MAX_WINDOW_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int SAMPLE_W    = 32;
    localparam int COST_W      = 40;
    localparam int LEN_W       = 9;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = COST_W + SAMPLE_W;

    localparam logic [APB_AW-3:0] REG_WINDOW_LEN = '0;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_REMOVE,
        CELL_INSERT,
        CELL_ROTATE
    } t_cell_op;

endpackage

// ----- hw/rtl/swmc_cell.sv -----
// one cell of the sorted sample chain: value, valid flag and neighbor exchange
module swmc_cell #(
    parameter int SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swmc_pkg::t_cell_op            i_op,
    input  logic signed [SAMPLE_BITS-1:0] i_key,
    input  logic signed [SAMPLE_BITS-1:0] i_left_val,
    input  logic                          i_left_vld,
    input  logic                          i_left_gt,
    input  logic signed [SAMPLE_BITS-1:0] i_right_val,
    input  logic                          i_right_vld,
    output logic signed [SAMPLE_BITS-1:0] o_val,
    output logic                          o_vld,
    output logic                          o_gt
);

    logic signed [SAMPLE_BITS-1:0] r_val;
    logic                          r_vld;
    logic                          w_ge;

    // empty cells sort above every sample
    assign o_gt  = !r_vld || (r_val > i_key);
    assign w_ge  = !r_vld || (r_val >= i_key);
    assign o_val = r_val;
    assign o_vld = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            case (i_op)
                swmc_pkg::CELL_CLEAR: begin
                    r_vld <= 1'b0;
                end
                swmc_pkg::CELL_REMOVE: begin
                    if (w_ge) begin
                        r_vld <= i_right_vld;
                    end
                end
                swmc_pkg::CELL_INSERT: begin
                    if (o_gt) begin
                        r_vld <= i_left_gt ? i_left_vld : 1'b1;
                    end
                end
                swmc_pkg::CELL_ROTATE: begin
                    r_vld <= i_right_vld;
                end
                default: begin
                    r_vld <= r_vld;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            swmc_pkg::CELL_REMOVE: begin
                if (w_ge) begin
                    r_val <= i_right_val;
                end
            end
            swmc_pkg::CELL_INSERT: begin
                if (o_gt) begin
                    r_val <= i_left_gt ? i_left_val : i_key;
                end
            end
            swmc_pkg::CELL_ROTATE: begin
                r_val <= i_right_val;
            end
            default: begin
                r_val <= r_val;
            end
        endcase
    end

endmodule

// ----- hw/rtl/swmc_ring.sv -----
// arrival order store of window samples, one port, read before write
module swmc_ring #(
    parameter int DEPTH = swmc_pkg::MAX_WINDOW_DEF,
    parameter int WIDTH = swmc_pkg::SAMPLE_BITS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

endmodule

// ----- hw/rtl/sliding_window_median_cost_top.sv -----
// sliding window median cost: top level with control, chain of sorted cells and arrival store
// items are taken only while idle, never before the last one is done: the accepting cycle reads
// the oldest sample, REMOVE takes it out of the chain once the window is full, INSERT puts in the
// new sample, SUM rotates the whole chain past the accumulator for sums and median, OUT registers
// the result and the block returns to idle to wait for the next item; a result holds until taken;
// an untaken one stalls the next item in its last step; synchronous active-low reset empties the window, len 1
module sliding_window_median_cost_top #(
    parameter int MAX_WINDOW  = swmc_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample
    input  logic [swmc_pkg::TDATA_IN_W-1:0]  i_s_tdata,
    input  logic                             i_s_tlast,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // window_cost [39:0], window_median [71:40]
    output logic [swmc_pkg::TDATA_OUT_W-1:0] o_m_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [swmc_pkg::APB_AW-1:0]      paddr,
    input  logic [swmc_pkg::APB_DW-1:0]      pwdata,
    output logic [swmc_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_SUM,
        ST_OUT
    } t_state;

    t_state                             r_state;
    logic [swmc_pkg::LEN_W-1:0]         r_wlen;
    logic [LW-1:0]                      r_cnt;
    logic [AW-1:0]                      r_wp;
    logic [AW-1:0]                      r_k;
    logic                               r_full;
    logic                               r_emit;
    logic                               r_last;
    logic signed [SAMPLE_BITS-1:0]      r_sample;
    logic signed [SAMPLE_BITS-1:0]      r_med;
    logic [swmc_pkg::COST_W-1:0]        r_acc;
    logic                               r_m_tvalid;
    logic [swmc_pkg::TDATA_OUT_W-1:0]   r_m_tdata;

    logic                               w_accept;
    logic                               w_cfg_wr;
    logic                               w_len_wr;
    logic                               w_can_out;
    logic [LW-1:0]                      w_len;
    logic [LW-1:0]                      w_lo;
    logic signed [SAMPLE_BITS-1:0]      w_sample;
    logic signed [SAMPLE_BITS-1:0]      w_oldest;
    logic signed [SAMPLE_BITS-1:0]      w_key;
    logic signed [swmc_pkg::COST_W-1:0] w_term;
    logic [swmc_pkg::COST_W-1:0]        w_cost;
    swmc_pkg::t_cell_op                 w_op;

    logic signed [SAMPLE_BITS-1:0]      c_val   [MAX_WINDOW];
    logic                               c_vld   [MAX_WINDOW];
    logic                               c_gt    [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0]      l_val   [MAX_WINDOW];
    logic                               l_vld   [MAX_WINDOW];
    logic                               l_gt    [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0]      rt_val  [MAX_WINDOW];
    logic                               rt_vld  [MAX_WINDOW];

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_len_wr   = w_cfg_wr &&
                        (paddr[swmc_pkg::APB_AW-1:2] == swmc_pkg::REG_WINDOW_LEN);
    assign o_s_tready = (r_state == ST_IDLE) && !w_cfg_wr;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign pready     = 1'b1;
    assign prdata     = (paddr[swmc_pkg::APB_AW-1:2] == swmc_pkg::REG_WINDOW_LEN) ?
                        swmc_pkg::APB_DW'(r_wlen) : '0;

    assign w_len = (r_wlen == '0) ? LW'(1) :
                   (int'(r_wlen) > MAX_WINDOW) ? LW'(MAX_WINDOW) : LW'(r_wlen);
    assign w_lo  = LW'(((LW + 1)'(w_len) + (LW + 1)'(1)) >> 1);

    assign w_sample  = i_s_tdata[SAMPLE_BITS-1:0];
    assign w_key     = (r_state == ST_REMOVE) ? w_oldest : r_sample;
    assign w_term    = swmc_pkg::COST_W'(c_val[0]);
    assign w_cost    = r_acc + (w_len[0] ? swmc_pkg::COST_W'(r_med) : '0);
    assign w_can_out = (r_state == ST_OUT) && (!r_emit || !r_m_tvalid || i_m_tready);

    always_comb begin
        case (r_state)
            ST_IDLE:   w_op = w_len_wr ? swmc_pkg::CELL_CLEAR : swmc_pkg::CELL_HOLD;
            ST_REMOVE: w_op = r_full ? swmc_pkg::CELL_REMOVE : swmc_pkg::CELL_HOLD;
            ST_INSERT: w_op = swmc_pkg::CELL_INSERT;
            ST_SUM:    w_op = swmc_pkg::CELL_ROTATE;
            ST_OUT:    w_op = (w_can_out && r_last) ? swmc_pkg::CELL_CLEAR
                                                    : swmc_pkg::CELL_HOLD;
            default:   w_op = swmc_pkg::CELL_HOLD;
        endcase
    end

    swmc_ring #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_en    (w_accept),
        .i_addr  (r_wp),
        .i_wdata (w_sample),
        .o_rdata (w_oldest)
    );

    for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign l_val[gi] = w_key;
            assign l_vld[gi] = 1'b0;
            assign l_gt[gi]  = 1'b0;
        end else begin : g_body
            assign l_val[gi] = c_val[gi-1];
            assign l_vld[gi] = c_vld[gi-1];
            assign l_gt[gi]  = c_gt[gi-1];
        end
        if (gi == MAX_WINDOW - 1) begin : g_tail
            // wrap to the head only while rotating
            assign rt_val[gi] = c_val[0];
            assign rt_vld[gi] = (w_op == swmc_pkg::CELL_ROTATE) && c_vld[0];
        end else begin : g_mid
            assign rt_val[gi] = c_val[gi+1];
            assign rt_vld[gi] = c_vld[gi+1];
        end

        swmc_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (w_op),
            .i_key       (w_key),
            .i_left_val  (l_val[gi]),
            .i_left_vld  (l_vld[gi]),
            .i_left_gt   (l_gt[gi]),
            .i_right_val (rt_val[gi]),
            .i_right_vld (rt_vld[gi]),
            .o_val       (c_val[gi]),
            .o_vld       (c_vld[gi]),
            .o_gt        (c_gt[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wlen     <= swmc_pkg::LEN_W'(1);
            r_cnt      <= '0;
            r_wp       <= '0;
            r_k        <= '0;
            r_full     <= 1'b0;
            r_emit     <= 1'b0;
            r_last     <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (r_m_tvalid && i_m_tready && !(w_can_out && r_emit)) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_len_wr) begin
                        r_wlen <= pwdata[swmc_pkg::LEN_W-1:0];
                        r_cnt  <= '0;
                        r_wp   <= '0;
                    end else if (w_accept) begin
                        r_sample <= w_sample;
                        r_last   <= i_s_tlast;
                        r_full   <= (r_cnt == w_len);
                        if ((LW + 1)'(r_wp) + (LW + 1)'(1) >= (LW + 1)'(w_len)) begin
                            r_wp <= '0;
                        end else begin
                            r_wp <= r_wp + AW'(1);
                        end
                        r_state <= ST_REMOVE;
                    end
                end
                ST_REMOVE: begin
                    r_state <= ST_INSERT;
                end
                ST_INSERT: begin
                    if (!r_full) begin
                        r_cnt <= r_cnt + LW'(1);
                    end
                    r_emit  <= r_full || ((LW + 1)'(r_cnt) + (LW + 1)'(1) == (LW + 1)'(w_len));
                    r_acc   <= '0;
                    r_k     <= '0;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    // acc holds upper sum minus lower sum
                    if (c_vld[0]) begin
                        if (LW'(r_k) < w_lo) begin
                            r_acc <= r_acc - w_term;
                        end else begin
                            r_acc <= r_acc + w_term;
                        end
                    end
                    if (LW'(r_k) == w_lo - LW'(1)) begin
                        r_med <= c_val[0];
                    end
                    r_k <= r_k + AW'(1);
                    if (r_k == AW'(MAX_WINDOW - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_can_out) begin
                        if (r_emit) begin
                            r_m_tvalid <= 1'b1;
                            r_m_tdata  <= {swmc_pkg::SAMPLE_W'(r_med), w_cost};
                        end
                        if (r_last) begin
                            r_cnt <= '0;
                            r_wp  <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
